// ===== hdl/kvx_pkg.sv =====
// ----------------------------------------------------------------------------
// kvx_pkg
// shared types and constants of the json key value extractor
// ----------------------------------------------------------------------------
package kvx_pkg;

   localparam int MAX_LINE_DEFAULT = 1024;
   localparam int MAX_KEY_DEFAULT  = 8;

   localparam int CHAR_W     = 8;
   localparam int KEY_W      = 64;
   localparam int KEY_LEN_W  = 4;
   localparam int POS_OUT_W  = 11;
   localparam int NUMBER_W   = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CHARS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 1'b1;

   localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 4'd1;

   typedef struct packed {
      logic [KEY_W-1:0]     key_chars;
      logic [KEY_LEN_W-1:0] key_length;
   } cfg_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } in_item_type;

   typedef struct packed {
      logic                 found;
      logic [POS_OUT_W-1:0] value_start;
      logic [POS_OUT_W-1:0] value_end;
      logic [NUMBER_W-1:0]  number;
      logic                 quoted;
      logic                 too_long;
   } rsp_item_type;

endpackage

// ===== hdl/kvx_req_if.sv =====
// ----------------------------------------------------------------------------
// kvx_req_if
// character channel: one byte of the line per item
// ----------------------------------------------------------------------------
interface kvx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hdl/kvx_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kvx_rsp_if
// result channel: one item per line
// ----------------------------------------------------------------------------
interface kvx_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [10:0] value_start;
   logic [10:0] value_end;
   logic [31:0] number;
   logic        quoted;
   logic        too_long;

   modport source (output valid, output found, output value_start, output value_end,
                   output number, output quoted, output too_long, input ready);
   modport sink   (input valid, input found, input value_start, input value_end,
                   input number, input quoted, input too_long, output ready);
endinterface

// ===== hdl/kvx_csr.sv =====
// ----------------------------------------------------------------------------
// kvx_csr
// key configuration registers, write only
// ----------------------------------------------------------------------------
module kvx_csr
   import kvx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_CHARS:  cfg_in.key_chars  = csr_write_data[KEY_W-1:0];
            CSR_KEY_LENGTH: cfg_in.key_length = csr_write_data[KEY_LEN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_chars  <= '0;
         cfg_ff.key_length <= KEY_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/kvx_in_stage.sv =====
// ----------------------------------------------------------------------------
// kvx_in_stage
// input register for one character item
// ----------------------------------------------------------------------------
module kvx_in_stage
   import kvx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   kvx_req_if.sink     req_ch,
   input  logic        advance,
   output logic        item_valid,
   output in_item_type item
);

   logic        valid_ff, valid_in;
   in_item_type item_ff;
   logic        take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign valid_in     = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.character <= req_ch.character;
         item_ff.last      <= req_ch.last;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/kvx_parser.sv =====
// ----------------------------------------------------------------------------
// kvx_parser
// per-character line state: key match, skip, value scan and result forming
// ----------------------------------------------------------------------------
module kvx_parser
   import kvx_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEFAULT,
   parameter int MAX_KEY  = MAX_KEY_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         step,
   input  in_item_type  item,
   output logic         result_valid,
   output rsp_item_type result
);

   localparam int POS_W = $clog2(MAX_LINE + 1);
   localparam int EXT_W = (POS_W > POS_OUT_W) ? POS_W : POS_OUT_W;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

   localparam logic [2:0] PH_MATCH    = 3'd0;
   localparam logic [2:0] PH_SKIP_ONE = 3'd1;
   localparam logic [2:0] PH_SKIP_WS  = 3'd2;
   localparam logic [2:0] PH_VALUE    = 3'd3;
   localparam logic [2:0] PH_DONE     = 3'd4;

   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3a;
   localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
   localparam logic [CHAR_W-1:0] CH_COMMA     = 8'h2c;
   localparam logic [CHAR_W-1:0] CH_BRACE     = 8'h7d;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5c;
   localparam logic [NUMBER_W-1:0] DIGIT_ZERO = 32'd48;

   logic [2:0]            phase_ff, phase_in;
   logic [KEY_LEN_W-1:0]  mc_ff, mc_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [POS_W-1:0]      start_ff, start_in;
   logic [NUMBER_W-1:0]   acc_ff, acc_in;
   logic [CHAR_W-1:0]     prev_ff, prev_in;
   logic                  quote_ff, quote_in;
   logic                  ovf_ff, ovf_in;

   logic [CHAR_W-1:0]     c;
   logic                  sat;
   logic [KEY_LEN_W-1:0]  klen;
   logic [CHAR_W-1:0]     key_cur;
   logic [KEY_LEN_W-1:0]  mc_next;
   logic [NUMBER_W-1:0]   digit;
   logic                  term;
   logic                  term_hit;
   logic [EXT_W-1:0]      start_ext;
   logic [EXT_W-1:0]      end_ext;

   assign c     = item.character;
   assign sat   = (pos_ff >= POS_MAX);
   assign digit = {{(NUMBER_W-CHAR_W){1'b0}}, c} - DIGIT_ZERO;

   // zero acts as one, above the limit acts as the limit
   always_comb begin
      if (cfg.key_length == '0)
         klen = KEY_LEN_W'(1);
      else if (cfg.key_length > KEY_LEN_W'(MAX_KEY))
         klen = KEY_LEN_W'(MAX_KEY);
      else
         klen = cfg.key_length;
   end

   assign key_cur = cfg.key_chars[{mc_ff[2:0], 3'b000} +: CHAR_W];
   assign mc_next = (c == key_cur) ? mc_ff + KEY_LEN_W'(1) :
                    ((c == cfg.key_chars[CHAR_W-1:0]) ? KEY_LEN_W'(1) : '0);

   assign term = quote_ff ? ((c == CH_QUOTE) && (prev_ff != CH_BACKSLASH))
                          : ((c == CH_COMMA) || (c == CH_BRACE));
   assign term_hit = (phase_ff == PH_VALUE) && term;

   always_comb begin
      phase_in = phase_ff;
      mc_in    = mc_ff;
      start_in = start_ff;
      acc_in   = acc_ff;
      quote_in = quote_ff;
      pos_in   = sat ? POS_MAX : pos_ff + POS_W'(1);
      ovf_in   = ovf_ff || sat;
      prev_in  = c;

      unique case (phase_ff)
         PH_MATCH: begin
            mc_in = mc_next;
            if (mc_next >= klen) begin
               mc_in    = '0;
               phase_in = PH_SKIP_ONE;
            end
         end
         PH_SKIP_ONE: phase_in = PH_SKIP_WS;
         PH_SKIP_WS: begin
            if (!((c == CH_SPACE) || (c == CH_TAB) || (c == CH_COLON))) begin
               quote_in = (c == CH_QUOTE);
               if (c == CH_QUOTE) begin
                  start_in = sat ? POS_MAX : pos_ff + POS_W'(1);
                  acc_in   = '0;
               end else begin
                  start_in = pos_ff;
                  acc_in   = digit;
               end
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (term)
               phase_in = PH_DONE;
            else
               acc_in = (acc_ff << 3) + (acc_ff << 1) + digit;
         end
         default: phase_in = phase_ff;
      endcase

      // line end: back to the start of a fresh line
      if (item.last) begin
         phase_in = PH_MATCH;
         mc_in    = '0;
         pos_in   = '0;
         start_in = '0;
         acc_in   = '0;
         prev_in  = '0;
         quote_in = 1'b0;
         ovf_in   = 1'b0;
      end
   end

   assign start_ext = EXT_W'(start_ff);
   assign end_ext   = EXT_W'(pos_ff - POS_W'(1));

   always_comb begin
      result_valid = term_hit || (item.last && (phase_ff != PH_DONE));
      result.too_long = ovf_ff || sat;
      if (term_hit) begin
         result.found       = 1'b1;
         result.value_start = start_ext[POS_OUT_W-1:0];
         result.value_end   = end_ext[POS_OUT_W-1:0];
         result.number      = acc_ff;
         result.quoted      = quote_ff;
      end else begin
         result.found       = 1'b0;
         result.value_start = '0;
         result.value_end   = '0;
         result.number      = '0;
         result.quoted      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MATCH;
         mc_ff    <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
         acc_ff   <= '0;
         prev_ff  <= '0;
         quote_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         mc_ff    <= mc_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         acc_ff   <= acc_in;
         prev_ff  <= prev_in;
         quote_ff <= quote_in;
         ovf_ff   <= ovf_in;
      end
   end

   // a found result only comes out of the value scan
   a_found_from_value: assert property (@(posedge clock) disable iff (reset)
      step && result_valid && result.found |-> phase_ff == PH_VALUE)
      else $error("found result outside value scan");

   // a line end always leaves a clean line state
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> pos_ff == '0 && phase_ff == PH_MATCH && !ovf_ff)
      else $error("line state not cleared after last item");

   // partial key match only lives in the match phase
   a_mc_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_MATCH |-> mc_ff == '0)
      else $error("match count set outside match phase");

   // position saturates, overflow flag follows
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      step && sat && !item.last |=> pos_ff == POS_MAX && ovf_ff)
      else $error("position saturation broken");

endmodule

// ===== hdl/kvx_out_stage.sv =====
// ----------------------------------------------------------------------------
// kvx_out_stage
// result register in front of the result channel
// ----------------------------------------------------------------------------
module kvx_out_stage
   import kvx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         space,
   kvx_rsp_if.source    rsp_ch
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign space    = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.found       = item_ff.found;
   assign rsp_ch.value_start = item_ff.value_start;
   assign rsp_ch.value_end   = item_ff.value_end;
   assign rsp_ch.number      = item_ff.number;
   assign rsp_ch.quoted      = item_ff.quoted;
   assign rsp_ch.too_long    = item_ff.too_long;

endmodule

// ===== hdl/json_key_value_extractor.sv =====
// ----------------------------------------------------------------------------
// json_key_value_extractor
// finds a configured quoted key in a character stream and reports its value
// ----------------------------------------------------------------------------
// A line enters one character per item on req_ch, with last set on its final
// character. The block searches for the key text held in key_chars (quotes
// included, key_length characters), skips one character and then any spaces,
// tabs and colons, and scans the value: a quoted value ends at the next quote
// not preceded by a backslash, any other value at a comma or closing brace.
// Each line gives at most one item on rsp_ch: a found item when the value ends,
// or a not-found item at line end if no value was closed; characters after a
// found value are ignored. Rate is one character per clock cycle while req_ch
// does not stall: each item passes an input register, a state update (key
// compare, phase update, times-ten fold) and the result register. req_ch
// stalls only while the result register holds an untaken item and the
// waiting character would make another. Positions saturate at MAX_LINE and
// then set too_long. Write the key registers only while no line is in flight.
// ----------------------------------------------------------------------------
module json_key_value_extractor
   import kvx_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEFAULT,
   parameter int MAX_KEY  = MAX_KEY_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   kvx_req_if.sink               req_ch,
   kvx_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type      cfg;
   logic         item_valid;
   in_item_type  item;
   logic         result_valid;
   rsp_item_type result;
   logic         space;
   logic         advance;

   // key registers
   kvx_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // character register
   kvx_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // the held character moves on unless it makes a result with nowhere to go
   assign advance = item_valid && (!result_valid || space);

   // line state and result forming
   kvx_parser #(
      .MAX_LINE (MAX_LINE),
      .MAX_KEY  (MAX_KEY)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (advance),
      .item         (item),
      .result_valid (result_valid),
      .result       (result)
   );

   // result register
   kvx_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && result_valid),
      .result (result),
      .space  (space),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== tb/kvx_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// kvx_tb_pkg
// character constants and the value extraction scoreboard for tb_top
// ----------------------------------------------------------------------------
package kvx_tb_pkg;
   import kvx_pkg::*;

   localparam int LINE_LIMIT = MAX_LINE_DEFAULT;
   localparam int KEY_LIMIT  = MAX_KEY_DEFAULT;

   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

   typedef enum logic [2:0] {
      SCAN_KEY,
      SKIP_ONE,
      SKIP_BLANKS,
      IN_VALUE,
      LINE_DONE
   } scan_phase_type;

   class extraction_scoreboard;
      logic [KEY_W-1:0]     key_chars;
      logic [KEY_LEN_W-1:0] key_length;

      scan_phase_type       phase;
      logic [3:0]           matched;
      logic [POS_OUT_W-1:0] position;
      logic [POS_OUT_W-1:0] start_pos;
      logic [NUMBER_W-1:0]  acc;
      logic [CHAR_W-1:0]    prev_char;
      logic                 quote_mode;
      logic                 overflow;

      rsp_item_type expected_values[$];

      int failures;
      int chars_seen;
      int lines_seen;
      int results_checked;
      int found_count;
      int overflow_count;

      function new();
         key_chars  = '0;
         key_length = KEY_LENGTH_RESET;
         failures = 0;
         chars_seen = 0;
         lines_seen = 0;
         results_checked = 0;
         found_count = 0;
         overflow_count = 0;
         clear_line();
      endfunction

      function void clear_line();
         phase      = SCAN_KEY;
         matched    = '0;
         position   = '0;
         start_pos  = '0;
         acc        = '0;
         prev_char  = '0;
         quote_mode = 1'b0;
         overflow   = 1'b0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_KEY_CHARS) begin
            key_chars = data[KEY_W-1:0];
         end else begin
            key_length = data[KEY_LEN_W-1:0];
         end
      endfunction

      function logic [CHAR_W-1:0] key_at(int idx);
         return key_chars[8*(idx & 7) +: 8];
      endfunction

      // zero acts as one, anything above the key store acts as full length
      function int key_len();
         int n;
         n = key_length;
         if (n == 0) n = 1;
         if (n > KEY_LIMIT) n = KEY_LIMIT;
         return n;
      endfunction

      function int pending();
         return expected_values.size();
      endfunction

      // one accepted character: advance the line state, queue any result it makes
      function void note_char(logic [CHAR_W-1:0] c, logic last);
         logic [POS_OUT_W-1:0] p;
         rsp_item_type         r;
         logic                 made;
         logic                 term;
         made = 1'b0;
         r    = '0;
         p    = position;
         chars_seen++;
         if (p >= LINE_LIMIT) begin
            p = LINE_LIMIT;
            position = p;
            overflow = 1'b1;
         end else begin
            position = p + 1'b1;
         end
         case (phase)
            SCAN_KEY: begin
               if (c == key_at(matched)) begin
                  matched++;
               end else begin
                  matched = (c == key_at(0)) ? 4'd1 : 4'd0;
               end
               if (matched >= key_len()) begin
                  matched = '0;
                  phase = SKIP_ONE;
               end
            end
            SKIP_ONE: phase = SKIP_BLANKS;
            SKIP_BLANKS: begin
               if (!(c == CH_SPACE || c == CH_TAB || c == CH_COLON)) begin
                  quote_mode = (c == CH_QUOTE);
                  if (quote_mode) begin
                     start_pos = (p + 1 > LINE_LIMIT) ? LINE_LIMIT : p + 1;
                     acc = '0;
                  end else begin
                     start_pos = p;
                     acc = 32'(c) - 32'd48;
                  end
                  phase = IN_VALUE;
               end
            end
            IN_VALUE: begin
               if (quote_mode) begin
                  term = (c == CH_QUOTE) && (prev_char != CH_BSLASH);
               end else begin
                  term = (c == CH_COMMA) || (c == CH_RBRACE);
               end
               if (term) begin
                  r.found       = 1'b1;
                  r.value_start = start_pos;
                  r.value_end   = p - 1'b1;
                  r.number      = acc;
                  r.quoted      = quote_mode;
                  r.too_long    = overflow;
                  made  = 1'b1;
                  phase = LINE_DONE;
               end else begin
                  acc = acc * 32'd10 + 32'(c) - 32'd48;
               end
            end
            default: ;
         endcase
         prev_char = c;
         if (last) begin
            if (!made && phase != LINE_DONE) begin
               r = '0;
               r.too_long = overflow;
               made = 1'b1;
            end
            clear_line();
            lines_seen++;
         end
         if (made) expected_values.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_values.size() == 0) begin
            $display("%0t: result with none expected: found %0d start %0d end %0d number %0d",
                     $time, got.found, got.value_start, got.value_end, got.number);
            failures++;
            return;
         end
         want = expected_values.pop_front();
         results_checked++;
         if (want.found) found_count++;
         if (want.too_long) overflow_count++;
         compare_field("found", want.found, got.found);
         compare_field("value_start", want.value_start, got.value_start);
         compare_field("value_end", want.value_end, got.value_end);
         compare_field("number", want.number, got.number);
         compare_field("quoted", want.quoted, got.quoted);
         compare_field("too_long", want.too_long, got.too_long);
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the json key value extractor
// ----------------------------------------------------------------------------
// Lines of characters go in one item at a time; each accepted character is
// run through a scoreboard that tracks the key search and value scan and
// queues the result the line should produce. Every result taken from the
// block is checked field by field against the oldest queued one. A short
// hand-written part comes first, then random lines under several key
// settings, then one line past the position limit.
// ----------------------------------------------------------------------------
module tb_top;
   import kvx_pkg::*;
   import kvx_tb_pkg::*;

   localparam int PHASE_ITEMS   = 40;         // short-line characters per key setting
   localparam int SETTLE_CYCLES = 8;          // settle time for trailing characters after the last result
   localparam int RUN_LIMIT     = 2_400_000;  // time units, far beyond the slowest run

   logic clock;
   logic reset = 1'b1;

   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   kvx_req_if req_ch();
   kvx_rsp_if rsp_ch();

   json_key_value_extractor dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   extraction_scoreboard sb;

   logic [CHAR_W-1:0] line_buf[$];   // the line being sent
   int hold_request = 0;             // receiver hold-off asked by the stimulus, in cycles
   int settings_used = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // monitors: both channels sampled at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_char(req_ch.character, req_ch.last);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result({rsp_ch.found, rsp_ch.value_start, rsp_ch.value_end,
                          rsp_ch.number, rsp_ch.quoted, rsp_ch.too_long});
      end
   end

   // -------------------------------------------------------------------------
   // result side: random stall before each item, with calm stretches and
   // one long hold-off when the stimulus asks for it
   // -------------------------------------------------------------------------
   initial begin : result_taker
      int stall;
      bit steady;
      steady = 1'b0;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 15) == 0) steady = !steady;
         stall = steady ? 0 : $urandom_range(0, 16);
         if (hold_request > 0) begin
            // block fills its result register and stops taking characters
            stall = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // character side
   // -------------------------------------------------------------------------

   // send line_buf with last on its final character; some lines go back to back
   task automatic send_line();
      int i;
      int gap;
      bit steady;
      steady = ($urandom_range(0, 3) == 0);
      for (i = 0; i < line_buf.size(); i++) begin
         gap = steady ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.character <= line_buf[i];
         req_ch.last      <= (i == line_buf.size() - 1);
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
      end
   endtask

   // stop sending, let every queued result arrive, then let trailing
   // characters that make no result clear the pipeline
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_register(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // length goes in the low nibble, upper data bits are noise the block drops
   task automatic configure(logic [KEY_W-1:0] key, int length_code);
      logic [CSR_DATA_W-1:0] data;
      data = {$urandom, $urandom};
      data[KEY_LEN_W-1:0] = length_code[KEY_LEN_W-1:0];
      write_register(CSR_KEY_CHARS, key);
      write_register(CSR_KEY_LENGTH, data);
      settings_used++;
   endtask

   // key text into the low bytes, unused bytes random
   function automatic logic [KEY_W-1:0] pack_key(string s);
      logic [KEY_W-1:0] k;
      int i;
      k = {$urandom, $urandom};
      for (i = 0; i < s.len() && i < KEY_LIMIT; i++) k[8*i +: 8] = s[i];
      return k;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char();
      return 8'(CH_ZERO + $urandom_range(0, 9));
   endfunction

   task automatic load_text(string s);
      int i;
      line_buf.delete();
      for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   // one random line: mostly prefix, key, skip, blanks, value, terminator and
   // tail, with truncated, unterminated and pure noise lines mixed in
   task automatic compose_line();
      int kind;
      int n;
      int m;
      int i;
      line_buf.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         n = $urandom_range(1, 24);
         repeat (n) line_buf.push_back(8'($urandom));
      end else begin
         // prefix, partial keys force the mismatch retest
         n = $urandom_range(0, 4);
         repeat (n) begin
            case ($urandom_range(0, 3))
               0: line_buf.push_back(8'($urandom));
               1: line_buf.push_back(CH_LBRACE);
               2: line_buf.push_back(CH_SPACE);
               default: begin
                  m = $urandom_range(0, sb.key_len() - 1);
                  for (i = 0; i < m; i++) line_buf.push_back(sb.key_at(i));
               end
            endcase
         end
         for (i = 0; i < sb.key_len(); i++) line_buf.push_back(sb.key_at(i));
         // the skipped character
         case ($urandom_range(0, 3))
            0: line_buf.push_back(8'($urandom));
            1: line_buf.push_back(CH_QUOTE);
            default: line_buf.push_back(CH_COLON);
         endcase
         n = $urandom_range(0, 3);
         repeat (n) begin
            case ($urandom_range(0, 2))
               0: line_buf.push_back(CH_SPACE);
               1: line_buf.push_back(CH_TAB);
               default: line_buf.push_back(CH_COLON);
            endcase
         end
         if ($urandom_range(0, 2) == 0) begin
            // quoted value with escaped quotes and raw bytes
            line_buf.push_back(CH_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
               case ($urandom_range(0, 5))
                  0: begin
                     line_buf.push_back(CH_BSLASH);
                     line_buf.push_back(CH_QUOTE);
                  end
                  1: line_buf.push_back(8'($urandom));
                  2: line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
                  default: line_buf.push_back(digit_char());
               endcase
            end
            if (kind != 8) line_buf.push_back(CH_QUOTE);
         end else begin
            // bare number, sometimes long enough to wrap
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
            repeat (n) begin
               line_buf.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : digit_char());
            end
            if (kind != 8) line_buf.push_back($urandom_range(0, 1) ? CH_COMMA : CH_RBRACE);
         end
         // tail after the value is ignored by the block
         n = $urandom_range(0, 4);
         repeat (n) line_buf.push_back($urandom_range(0, 1) ? 8'($urandom) : CH_COMMA);
         if (kind == 7) begin
            n = $urandom_range(1, line_buf.size());
            while (line_buf.size() > n) void'(line_buf.pop_back());
         end
      end
   endtask

   // lines past the position limit: filler then key, or a value that never ends
   task automatic compose_long_line(bit runaway);
      int n;
      int i;
      line_buf.delete();
      if (!runaway) begin
         n = $urandom_range(1020, 1030);
         repeat (n) line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
      for (i = 0; i < sb.key_len(); i++) line_buf.push_back(sb.key_at(i));
      line_buf.push_back(CH_COLON);
      if (runaway) begin
         repeat (LINE_LIMIT + 6) line_buf.push_back(digit_char());
      end else if ($urandom_range(0, 1)) begin
         line_buf.push_back(CH_QUOTE);
         repeat (3) line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
         line_buf.push_back(CH_QUOTE);
         line_buf.push_back(CH_RBRACE);
      end else begin
         repeat (3) line_buf.push_back(digit_char());
         line_buf.push_back(CH_COMMA);
      end
   endtask

   task automatic random_phase(logic [KEY_W-1:0] key, int length_code, int hold, int budget);
      int sent;
      wait_idle();
      configure(key, length_code);
      hold_request = hold;
      sent = 0;
      while (sent < budget) begin
         compose_line();
         send_line();
         sent += line_buf.size();
      end
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      req_ch.valid     <= 1'b0;
      req_ch.character <= '0;
      req_ch.last      <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key is a single nul byte: all-ones miss, nul hit, bare value
      line_buf = {8'hFF, 8'h00, CH_COLON, 8'h39, CH_RBRACE};
      send_line();

      wait_idle();
      configure(pack_key("\"k\""), 3);
      // doubled quote retests the first key char, escaped quote inside value,
      // characters after the value are dropped
      load_text("\"\"k\":\"a\\\"b\"}x");
      send_line();
      // value opens on a comma, which does not end it
      load_text("\"k\"x,5}");
      send_line();
      // line ends inside the key
      load_text("\"k");
      send_line();

      // random lines under several key settings, extremes included
      random_phase('0, 1, 400, PHASE_ITEMS);
      random_phase(pack_key("\"id\""), 4, 0, PHASE_ITEMS);
      random_phase(pack_key("\"sensor\""), 8, 300, PHASE_ITEMS);
      random_phase('1, 15, 0, PHASE_ITEMS);
      random_phase(pack_key("\""), 0, 0, PHASE_ITEMS);
      random_phase({$urandom, $urandom}, $urandom_range(1, 8), 0, PHASE_ITEMS);
      random_phase({$urandom, $urandom}, $urandom_range(9, 14), 0, PHASE_ITEMS);

      // positions saturate and flag too_long
      wait_idle();
      configure(pack_key("\"rh\""), 4);
      compose_long_line(1'b0);
      send_line();

      wait_idle();
      $display("run covered %0d lines (%0d characters) under %0d key settings",
               sb.lines_seen, sb.chars_seen, settings_used);
      $display("%0d results checked, %0d with value found, %0d past the line limit",
               sb.results_checked, sb.found_count, sb.overflow_count);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("** json_key_value_extractor: PASSED **");
      end else begin
         $display("** json_key_value_extractor: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("** json_key_value_extractor: FAILED **");
      $finish;
   end

endmodule
